>>> rtl/core/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg: shared types and constants for the ordered list engine
// Holds op codes, status codes and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int Depth = 64;
    localparam int AddrW = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    typedef enum logic [3:0] {
        OP_INS_FRONT  = 4'd0,
        OP_INS_BACK   = 4'd1,
        OP_INS_SORTED = 4'd2,
        OP_RM_FRONT   = 4'd3,
        OP_RM_BACK    = 4'd4,
        OP_RM_KEY     = 4'd5,
        OP_READ_POS   = 4'd6,
        OP_FIND       = 4'd7,
        OP_CLEAR      = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_FULL   = 3'd2,
        ST_NOKEY  = 3'd3,
        ST_BADPOS = 3'd4
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load;      // capture input item
        logic             rd_en;     // issue memory read at rd_addr
        logic [AddrW-1:0] rd_addr;
        logic             wr_new;    // write captured key/payload at wr_addr
        logic             wr_mov;    // write last read data at wr_addr
        logic [AddrW-1:0] wr_addr;
        logic             cnt_inc;
        logic             cnt_dec;
        logic             cnt_clr;
        logic             res_load;  // capture result
        logic             res_hit;   // result carries read data
        status_t          res_status;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t              op;
        logic [CntW-1:0]  count;
        logic [7:0]       position;
        logic             key_eq;    // read data key equals captured key
        logic             key_lt;    // read data key less than captured key
        logic             key_gt;    // read data key greater than captured key
    } dp_sts_t;

endpackage

>>> rtl/core/bole_datapath.sv
// ----------------------------------------------------------------------------
// bole_datapath: entry memories, count register, item and result registers
// Executes one read and one write per cycle as the controller commands.
// ----------------------------------------------------------------------------
module bole_datapath
    import bole_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [3:0]         s_op,
    input  logic signed [31:0] s_in_key,
    input  logic [31:0]        s_in_payload,
    input  logic [7:0]         s_position,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_out_key,
    output logic [31:0]        m_out_payload,
    output logic [6:0]         m_entry_count,
    output logic               m_list_empty
);

    logic signed [31:0] key_mem [Depth];
    logic [31:0]        pay_mem [Depth];

    logic [3:0]         op_reg;
    logic signed [31:0] key_reg;
    logic [31:0]        pay_reg;
    logic [7:0]         pos_reg;
    logic [CntW-1:0]    count_reg, count_next;
    logic signed [31:0] rd_key_reg;
    logic [31:0]        rd_pay_reg;

    logic [2:0]         res_status_reg;
    logic signed [31:0] res_key_reg;
    logic [31:0]        res_pay_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_op;
            key_reg <= s_in_key;
            pay_reg <= s_in_payload;
            pos_reg <= s_position;
        end
        if (cmd.rd_en) begin
            rd_key_reg <= key_mem[cmd.rd_addr];
            rd_pay_reg <= pay_mem[cmd.rd_addr];
        end
        if (cmd.wr_new) begin
            key_mem[cmd.wr_addr] <= key_reg;
            pay_mem[cmd.wr_addr] <= pay_reg;
        end else if (cmd.wr_mov) begin
            key_mem[cmd.wr_addr] <= rd_key_reg;
            pay_mem[cmd.wr_addr] <= rd_pay_reg;
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_key_reg    <= cmd.res_hit ? rd_key_reg : 32'sd0;
            res_pay_reg    <= cmd.res_hit ? rd_pay_reg : 32'd0;
        end
    end

    always_comb begin
        count_next = count_reg;
        priority if (cmd.cnt_clr) begin
            count_next = '0;
        end else if (cmd.cnt_inc) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign sts.op       = op_t'(op_reg);
    assign sts.count    = count_reg;
    assign sts.position = pos_reg;
    assign sts.key_eq   = (rd_key_reg == key_reg);
    assign sts.key_lt   = (rd_key_reg < key_reg);
    assign sts.key_gt   = (rd_key_reg > key_reg);

    assign m_status      = res_status_reg;
    assign m_out_key     = res_key_reg;
    assign m_out_payload = res_pay_reg;
    assign m_entry_count = 7'(count_reg);
    assign m_list_empty  = (count_reg == '0);

endmodule

>>> rtl/core/bole_ctrl.sv
// ----------------------------------------------------------------------------
// bole_ctrl: sequencer for list operations
// Walks the entry memory for searches, shifts entries to open or close gaps.
// ----------------------------------------------------------------------------
module bole_ctrl
    import bole_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DISP  = 8'b0000_0010,
        S_SRCH  = 8'b0000_0100,  // read issued at idx, compare next cycle
        S_SHUP  = 8'b0000_1000,  // move entry idx-1 to idx, walking down
        S_SHDN  = 8'b0001_0000,  // move entry idx+1 to idx, walking up
        S_RDW   = 8'b0010_0000,  // wait on read data for read by position
        S_WNEW  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [CntW-1:0] idx_reg, idx_next;   // position being examined or written
    logic [CntW-1:0] tgt_reg, tgt_next;   // insert target
    logic            pend_reg, pend_next; // read data ready for the shift step at idx_reg
    logic            busy_out_reg, busy_out_next;

    logic [CntW-1:0] cnt;
    assign cnt = sts.count;

    assign s_ready = (state_reg == S_IDLE) && !busy_out_reg;
    assign m_valid = busy_out_reg;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        tgt_next      = tgt_reg;
        pend_next     = 1'b0;
        busy_out_next = busy_out_reg;
        cmd           = '0;
        cmd.res_status = ST_OK;

        if (busy_out_reg && m_ready) begin
            busy_out_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                state_next = S_DONE;
                unique case (sts.op)
                    OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
                        if (cnt >= CntW'(Depth)) begin
                            cmd.res_status = ST_FULL;
                        end else if (sts.op == OP_INS_BACK || cnt == '0) begin
                            tgt_next   = (sts.op == OP_INS_BACK) ? cnt : '0;
                            state_next = S_WNEW;
                        end else if (sts.op == OP_INS_FRONT) begin
                            tgt_next   = '0;
                            idx_next   = cnt;
                            state_next = S_SHUP;
                        end else begin
                            // Scan from the head for the first key not less; at the head only a greater key stops
                            idx_next    = '0;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = '0;
                            pend_next   = 1'b1;
                            state_next  = S_SRCH;
                        end
                    end
                    OP_RM_FRONT, OP_RM_BACK: begin
                        if (cnt == '0) begin
                            cmd.res_status = ST_EMPTY;
                        end else if (sts.op == OP_RM_BACK) begin
                            cmd.cnt_dec = 1'b1;
                        end else begin
                            idx_next   = '0;
                            state_next = S_SHDN;
                        end
                    end
                    OP_RM_KEY, OP_FIND: begin
                        if (cnt == '0) begin
                            cmd.res_status = ST_EMPTY;
                        end else begin
                            idx_next    = '0;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = '0;
                            pend_next   = 1'b1;
                            state_next  = S_SRCH;
                        end
                    end
                    OP_READ_POS: begin
                        if (cnt == '0) begin
                            cmd.res_status = ST_EMPTY;
                        end else if (sts.position == 8'd0
                                     || {1'b0, sts.position} > 9'(cnt)) begin
                            cmd.res_status = ST_BADPOS;
                        end else begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = AddrW'(sts.position - 8'd1);
                            state_next  = S_RDW;
                        end
                    end
                    OP_CLEAR: cmd.cnt_clr = 1'b1;
                    default: ;
                endcase
                if (state_next == S_DONE) begin
                    cmd.res_load = 1'b1;
                end
            end
            S_SRCH: begin
                // Read data belongs to idx_reg
                if (sts.op == OP_INS_SORTED) begin
                    if (idx_reg == '0 && sts.key_gt) begin
                        tgt_next   = '0;
                        idx_next   = cnt;
                        state_next = S_SHUP;
                    end else if (idx_reg != '0 && !sts.key_lt) begin
                        tgt_next   = idx_reg;
                        idx_next   = cnt;
                        state_next = S_SHUP;
                    end else if (idx_reg + 1'b1 >= cnt) begin
                        tgt_next   = cnt;
                        state_next = S_WNEW;
                    end else begin
                        idx_next    = idx_reg + 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = AddrW'(idx_reg + 1'b1);
                    end
                end else if (sts.key_eq) begin
                    if (sts.op == OP_FIND) begin
                        cmd.res_load = 1'b1;
                        cmd.res_hit  = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        state_next = S_SHDN;
                    end
                end else if (idx_reg + 1'b1 >= cnt) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOKEY;
                    state_next     = S_DONE;
                end else begin
                    idx_next    = idx_reg + 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = AddrW'(idx_reg + 1'b1);
                end
            end
            S_SHUP: begin
                // Read idx-1 then write it at idx; pend marks data ready
                if (idx_reg == tgt_reg) begin
                    state_next = S_WNEW;
                end else if (!pend_reg) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = AddrW'(idx_reg - 1'b1);
                    pend_next   = 1'b1;
                end else begin
                    cmd.wr_mov  = 1'b1;
                    cmd.wr_addr = AddrW'(idx_reg);
                    idx_next    = idx_reg - 1'b1;
                end
            end
            S_SHDN: begin
                if (idx_reg + 1'b1 >= cnt) begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end else if (!pend_reg) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = AddrW'(idx_reg + 1'b1);
                    pend_next   = 1'b1;
                end else begin
                    cmd.wr_mov  = 1'b1;
                    cmd.wr_addr = AddrW'(idx_reg);
                    idx_next    = idx_reg + 1'b1;
                end
            end
            S_RDW: begin
                cmd.res_load = 1'b1;
                cmd.res_hit  = 1'b1;
                state_next   = S_DONE;
            end
            S_WNEW: begin
                cmd.wr_new   = 1'b1;
                cmd.wr_addr  = AddrW'(tgt_reg);
                cmd.cnt_inc  = 1'b1;
                cmd.res_load = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                // Result registers hold; raise valid
                busy_out_next = 1'b1;
                state_next    = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            busy_out_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            busy_out_reg <= busy_out_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        tgt_reg <= tgt_next;
    end

endmodule

>>> rtl/core/bounded_ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top: bounded ordered list of keyed entries
// Packed list of up to 64 entries held in key and payload memories.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Fields
//  --------+--------------------+----------------------------------------------
//  input   | s_valid / s_ready  | s_op, s_in_key, s_in_payload, s_position
//  result  | m_valid / m_ready  | m_status, m_out_key, m_out_payload,
//          |                    | m_entry_count, m_list_empty
//
// Searches read one entry at a time; shifts for inserts and removals read each
// entry moved and then write it one place along, so a front insert moves every
// entry already in the list.
// Reset clears the controller and the entry count; memory needs no clearing.
// One item is in work at a time; a held result stalls the next item.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top
    import bole_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_op,
    input  logic signed [31:0] s_in_key,
    input  logic [31:0]        s_in_payload,
    input  logic [7:0]         s_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_out_key,
    output logic [31:0]        m_out_payload,
    output logic [6:0]         m_entry_count,
    output logic               m_list_empty
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer: decodes the op and steps through searches and shifts
    bole_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage, compare and result registers
    bole_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_op          (s_op),
        .s_in_key      (s_in_key),
        .s_in_payload  (s_in_payload),
        .s_position    (s_position),
        .cmd           (cmd),
        .sts           (sts),
        .m_status      (m_status),
        .m_out_key     (m_out_key),
        .m_out_payload (m_out_payload),
        .m_entry_count (m_entry_count),
        .m_list_empty  (m_list_empty)
    );

endmodule

>>> dv/bounded_ordered_list_engine_top_tb.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top_tb: self-checking bench for the list engine
// Drives list operations through the input channel, predicts each result with
// a shadow-array model of the list and compares every result field by field.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top_tb;
    import bole_pkg::*;

    localparam int Cap = Depth;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] key;
        logic [31:0]        payload;
        logic [7:0]         position;
    } list_cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] key;
        logic [31:0]        payload;
        logic [6:0]         count;
        logic               empty;
    } list_rsp_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [3:0]         s_op;
    logic signed [31:0] s_in_key;
    logic [31:0]        s_in_payload;
    logic [7:0]         s_position;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_status;
    logic signed [31:0] m_out_key;
    logic [31:0]        m_out_payload;
    logic [6:0]         m_entry_count;
    logic               m_list_empty;

    bounded_ordered_list_engine_top dut (.*);

    // Shadow copy of the list, head at index 0
    logic signed [31:0] shadow_keys [Cap];
    logic [31:0]        shadow_pays [Cap];
    int                 shadow_count;

    list_cmd_t pending_cmds [$];
    list_rsp_t expected_rsps [$];
    int        error_count;
    bit        stim_done;
    bit        long_hold;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void shadow_put(int at, logic signed [31:0] k, logic [31:0] p);
        for (int i = shadow_count; i > at; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_pays[i] = shadow_pays[i-1];
        end
        shadow_keys[at] = k;
        shadow_pays[at] = p;
        shadow_count++;
    endfunction

    function automatic void shadow_take(int at);
        for (int i = at; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_pays[i] = shadow_pays[i+1];
        end
        shadow_count--;
    endfunction

    // Apply one operation to the shadow list and return the result it yields
    function automatic list_rsp_t apply_list_op(list_cmd_t c);
        list_rsp_t r;
        int        idx;
        bit        was_empty;
        r = '0;
        r.status = ST_OK;
        was_empty = (shadow_count == 0);
        idx = 0;
        case (c.op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
                if (shadow_count >= Cap) begin
                    r.status = ST_FULL;
                end else if (c.op == OP_INS_FRONT) begin
                    shadow_put(0, c.key, c.payload);
                end else if (c.op == OP_INS_BACK) begin
                    shadow_put(shadow_count, c.key, c.payload);
                end else if (was_empty || shadow_keys[0] > c.key) begin
                    shadow_put(0, c.key, c.payload);
                end else begin
                    idx = 1;
                    while (idx < shadow_count && shadow_keys[idx] < c.key) idx++;
                    shadow_put(idx, c.key, c.payload);
                end
            end
            OP_RM_FRONT, OP_RM_BACK: begin
                if (was_empty) r.status = ST_EMPTY;
                else shadow_take(c.op == OP_RM_FRONT ? 0 : shadow_count - 1);
            end
            OP_RM_KEY, OP_FIND: begin
                if (was_empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    while (idx < shadow_count && shadow_keys[idx] != c.key) idx++;
                    if (idx >= shadow_count) begin
                        r.status = ST_NOKEY;
                    end else if (c.op == OP_RM_KEY) begin
                        shadow_take(idx);
                    end else begin
                        r.key = shadow_keys[idx];
                        r.payload = shadow_pays[idx];
                    end
                end
            end
            OP_READ_POS: begin
                if (was_empty) begin
                    r.status = ST_EMPTY;
                end else if (c.position == 0 || c.position > shadow_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.key = shadow_keys[c.position-1];
                    r.payload = shadow_pays[c.position-1];
                end
            end
            OP_CLEAR: shadow_count = 0;
            default: ;
        endcase
        r.count = shadow_count[6:0];
        r.empty = (shadow_count == 0);
        return r;
    endfunction

    function automatic list_cmd_t make_cmd(logic [3:0] op, logic signed [31:0] k,
                                           logic [31:0] p, logic [7:0] pos);
        list_cmd_t c;
        c.op = op;
        c.key = k;
        c.payload = p;
        c.position = pos;
        return c;
    endfunction

    // Random key: mostly from a small set so finds and removals hit, sometimes wide
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    function automatic list_cmd_t random_cmd(int fill_bias);
        logic [3:0] op;
        int         w;
        w = $urandom_range(0, 99);
        // Lean toward inserts or removals to sweep the fill level
        if (w < fill_bias) op = 4'($urandom_range(0, 2));
        else if (w < 85) op = 4'($urandom_range(3, 7));
        else if (w < 95) op = 4'($urandom_range(0, 7));
        else if (w < 97) op = OP_CLEAR;
        else op = 4'($urandom_range(9, 15));
        return make_cmd(op, pick_key(), $urandom,
                        ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 66)));
    endfunction

    // Stimulus: directed corner cases, then random phases of filling and draining
    initial begin
        int bias;
        error_count = 0;
        stim_done = 1'b0;
        // Empty list
        pending_cmds.push_back(make_cmd(OP_RM_FRONT, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_RM_BACK, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_RM_KEY, 5, 0, 0));
        pending_cmds.push_back(make_cmd(OP_FIND, 5, 0, 0));
        pending_cmds.push_back(make_cmd(OP_READ_POS, 0, 0, 1));
        pending_cmds.push_back(make_cmd(OP_INS_SORTED, 10, 32'hffffffff, 0));
        pending_cmds.push_back(make_cmd(OP_INS_SORTED, 32'sh80000000, 32'h0, 0));
        pending_cmds.push_back(make_cmd(OP_INS_SORTED, 32'sh7fffffff, 32'h5a5a5a5a, 0));
        pending_cmds.push_back(make_cmd(OP_INS_SORTED, 10, 32'ha5a5a5a5, 0));
        pending_cmds.push_back(make_cmd(OP_INS_FRONT, -1, 32'h12345678, 0));
        pending_cmds.push_back(make_cmd(OP_INS_BACK, 10, 32'h1, 0));
        pending_cmds.push_back(make_cmd(OP_FIND, 10, 0, 0));
        pending_cmds.push_back(make_cmd(OP_FIND, 99, 0, 0));
        pending_cmds.push_back(make_cmd(OP_READ_POS, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_READ_POS, 0, 0, 6));
        pending_cmds.push_back(make_cmd(OP_READ_POS, 0, 0, 7));
        pending_cmds.push_back(make_cmd(OP_READ_POS, 0, 0, 8'hff));
        pending_cmds.push_back(make_cmd(OP_RM_KEY, -1, 0, 0));
        pending_cmds.push_back(make_cmd(OP_RM_KEY, 10, 0, 0));
        pending_cmds.push_back(make_cmd(OP_RM_FRONT, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_RM_BACK, 0, 0, 0));
        pending_cmds.push_back(make_cmd(4'd15, 32'sh7fffffff, 32'hffffffff, 8'hff));
        pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 0, 0));
        // Fill to capacity, then overflow with every insert op
        for (int i = 0; i < Cap + 2; i++)
            pending_cmds.push_back(make_cmd(OP_INS_BACK, i, $urandom, 0));
        pending_cmds.push_back(make_cmd(OP_INS_FRONT, 1, 2, 0));
        pending_cmds.push_back(make_cmd(OP_INS_SORTED, 1, 2, 0));
        pending_cmds.push_back(make_cmd(OP_READ_POS, 0, 0, 64));
        pending_cmds.push_back(make_cmd(OP_READ_POS, 0, 0, 65));
        pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 0, 0));
        for (int n = 0; n < 1500; n++) begin
            bias = ((n / 150) % 2 == 0) ? 60 : 25;
            pending_cmds.push_back(random_cmd(bias));
        end
        stim_done = 1'b1;
    end

    // Driver: bursts of items with random gaps
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left <= $urandom_range(1, 20);
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            // Item on the bus was taken (or none): decide what to offer next
            if (gap_left > 0 || pending_cmds.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                list_cmd_t c;
                c = pending_cmds.pop_front();
                expected_rsps.push_back(apply_list_op(c));
                s_valid <= 1'b1;
                s_op <= c.op;
                s_in_key <= c.key;
                s_in_payload <= c.payload;
                s_position <= c.position;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off early in the random part
    int rx_cycle;
    int hold_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_cycle <= 0;
            hold_left <= 0;
            long_hold <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (!long_hold && rx_cycle == 20000) begin
                long_hold <= 1'b1;
                hold_left <= 3000;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if ((rx_cycle / 256) % 3 == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected result, status %0d", $time, m_status);
                error_count++;
            end else begin
                list_rsp_t e;
                e = expected_rsps.pop_front();
                if (m_status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, m_status);
                    error_count++;
                end
                if (m_out_key !== e.key) begin
                    $display("%0t: out_key exp %0d got %0d", $time, e.key, m_out_key);
                    error_count++;
                end
                if (m_out_payload !== e.payload) begin
                    $display("%0t: out_payload exp %h got %h", $time, e.payload,
                             m_out_payload);
                    error_count++;
                end
                if (m_entry_count !== e.count) begin
                    $display("%0t: entry_count exp %0d got %0d", $time, e.count,
                             m_entry_count);
                    error_count++;
                end
                if (m_list_empty !== e.empty) begin
                    $display("%0t: list_empty exp %0d got %0d", $time, e.empty,
                             m_list_empty);
                    error_count++;
                end
            end
        end
    end

    // Reset, then wait for the stimulus to drain and the last result to land
    initial begin
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done && pending_cmds.size() == 0 && !s_valid
              && expected_rsps.size() == 0);
        repeat (200) @(posedge aclk);
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hold inputs known from time zero
    initial begin
        s_valid = 1'b0;
        s_op = '0;
        s_in_key = '0;
        s_in_payload = '0;
        s_position = '0;
        m_ready = 1'b0;
    end

    // Timeout
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
